// ===== sv/oal_pkg.sv =====
// oal_pkg: shared types and codes for the ordered array list.
// Used by oal_ctrl, oal_cell and ordered_array_list. No dependencies.
`default_nettype none

package oal_pkg;

  // command codes on the input channel
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_ERASE      = 3'd5,
    CMD_READ       = 3'd6
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // movement applied along the cell chain
  typedef enum logic [1:0] {
    SH_NONE  = 2'd0,
    SH_OPEN  = 2'd1,
    SH_CLOSE = 2'd2
  } shift_op_t;

  // decoded command handed from the controller to the datapath
  typedef struct packed {
    shift_op_t op;
    status_t   status;
    logic      rd_en;
  } cmd_dec_t;

endpackage

`default_nettype wire

// ===== sv/oal_cell.sv =====
// oal_cell: one storage cell of the list chain, holding a single entry.
// Depends on oal_pkg for the shift operation type.
`default_nettype none

module oal_cell
  import oal_pkg::*;
#(
  parameter int IDX = 0,
  parameter int AW  = 4
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire shift_op_t            op,
  input  wire logic [AW-1:0]        at,
  input  wire logic signed [31:0]   value,
  input  wire logic signed [31:0]   lower,
  input  wire logic signed [31:0]   upper,
  output logic signed [31:0]        data
);

  logic is_at;
  logic above;

  // where this cell sits relative to the gap
  assign is_at = (at == AW'(IDX));
  assign above = (AW'(IDX) > at);

  // open: take the new word at the gap, the lower neighbour above it
  // close: take the upper neighbour from the gap upwards
  always_ff @(posedge clk) begin
    if (en) begin
      case (op)
        SH_OPEN: begin
          if (is_at) begin
            data <= value;
          end else if (above) begin
            data <= lower;
          end
        end
        SH_CLOSE: begin
          if (is_at || above) begin
            data <= upper;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/oal_ctrl.sv =====
// oal_ctrl: entry count register and command decoder for the list.
// Depends on oal_pkg for command, status and shift codes.
`default_nettype none

module oal_ctrl
  import oal_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int FW       = 5
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [2:0]     command,
  input  wire logic [3:0]     position,
  output cmd_dec_t            dec,
  output logic [AW-1:0]       at,
  output logic [FW-1:0]       fill,
  output logic [FW-1:0]       fill_next
);

  localparam int CW = (FW > 4) ? FW : 4;

  logic          bad_pos;
  logic          full;
  logic          empty;

  assign bad_pos = (CW'(position) >= CW'(fill));
  assign full    = (fill >= FW'(CAPACITY));
  assign empty   = (fill == '0);

  // decode one command against the current count
  always_comb begin
    dec.op     = SH_NONE;
    dec.status = ST_OK;
    dec.rd_en  = 1'b0;
    at         = '0;
    fill_next  = fill;
    unique case (cmd_t'(command))
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) begin
          dec.status = ST_FULL;
        end else begin
          dec.op    = SH_OPEN;
          at        = (cmd_t'(command) == CMD_PUSH_FRONT) ? '0 : fill[AW-1:0];
          fill_next = FW'(fill + 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (empty) begin
          dec.status = ST_EMPTY;
        end else begin
          dec.op    = (cmd_t'(command) == CMD_POP_FRONT) ? SH_CLOSE : SH_NONE;
          fill_next = FW'(fill - 1'b1);
        end
      end
      CMD_INSERT: begin
        if (bad_pos) begin
          dec.status = ST_BADPOS;
        end else if (full) begin
          dec.status = ST_FULL;
        end else begin
          dec.op    = SH_OPEN;
          at        = AW'(position);
          fill_next = FW'(fill + 1'b1);
        end
      end
      CMD_ERASE: begin
        if (bad_pos) begin
          dec.status = ST_BADPOS;
        end else begin
          dec.op    = SH_CLOSE;
          at        = AW'(position);
          fill_next = FW'(fill - 1'b1);
        end
      end
      CMD_READ: begin
        if (bad_pos) begin
          dec.status = ST_BADPOS;
        end else begin
          dec.rd_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ordered_array_list.sv =====
// Ordered list of up to CAPACITY signed 32-bit words.
// Input channel (in_valid / in_stall) carries command, position and value;
// output channel (out_valid / out_stall) returns read_value, count, status.
// One result per command: the result appears in the
// output register the cycle after the command's transfer.
// Throughput is one command per cycle while in_stall is low: every cell
// of the chain moves one place at once, so inserts and erases never stall.
// The output register decouples the channels; a new command is taken while
// the previous result is being transferred. When the receiver stalls with a
// result held, in_stall rises and the result stays unchanged.
// Commands: push front/back, pop front/back, insert before position, erase
// at position, read at position. Full, empty and bad-position commands leave
// the list untouched and report their status; read_value is zero unless a
// read succeeds.
// Reset (rst, synchronous) empties the list and drops the output register;
// cell contents are not cleared, since entries are only read after writing.
// Depends on oal_pkg, oal_ctrl and oal_cell.
`default_nettype none

module ordered_array_list
  import oal_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          command,
  input  wire logic [3:0]          position,
  input  wire logic signed [31:0]  value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [31:0]       read_value,
  output logic [4:0]               count,
  output logic [1:0]               status
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FW   = $clog2(CAPACITY + 1);
  localparam int RD_N = (CAPACITY < 16) ? CAPACITY : 16;

  logic                accept;
  cmd_dec_t            dec;
  logic [AW-1:0]       at;
  logic [FW-1:0]       fill;
  logic [FW-1:0]       fill_next;
  logic signed [31:0]  data [CAPACITY];
  logic signed [31:0]  rd_data;

  // transfer handshake
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  oal_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .FW       (FW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .command   (command),
    .position  (position),
    .dec       (dec),
    .at        (at),
    .fill      (fill),
    .fill_next (fill_next)
  );

  // chain of cells; the ends see the new word and their own entry
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] lower;
    logic signed [31:0] upper;

    if (i == 0) begin : g_first
      assign lower = value;
    end else begin : g_mid_lo
      assign lower = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = data[i];
    end else begin : g_mid_hi
      assign upper = data[i+1];
    end

    oal_cell #(
      .IDX (i),
      .AW  (AW)
    ) u_cell (
      .clk   (clk),
      .en    (accept),
      .op    (dec.op),
      .at    (at),
      .value (value),
      .lower (lower),
      .upper (upper),
      .data  (data[i])
    );
  end

  // read select over the cells that a 4-bit position can reach
  always_comb begin
    rd_data = '0;
    for (int j = 0; j < RD_N; j++) begin
      if (dec.rd_en && (position == 4'(j))) begin
        rd_data = data[j];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= rd_data;
      count      <= 5'(fill_next);
      status     <= dec.status;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_reject_keeps_fill: assert property (@(posedge clk) disable iff (rst)
    accept && (dec.status != ST_OK) |=> fill == $past(fill))
    else $error("rejected command changed the entry count");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted command produced no result");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> read_value == '0)
    else $error("failed command returned non-zero read data");
`endif

endmodule

`default_nettype wire

// ===== dv/ordered_array_list_test.sv =====
// ordered_array_list_test: self-checking testbench for the ordered array list.
// Drives command transfers, predicts each result with a local list model and
// checks every result transfer. Depends on oal_pkg and ordered_array_list.
`timescale 1ns / 1ps

module ordered_array_list_test;
  import oal_pkg::*;

  localparam int CAPACITY = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT = 40;
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic signed [31:0] read_value;
    logic [4:0]         count;
    status_t            status;
  } list_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         command;
  logic [3:0]         position;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] read_value;
  logic [4:0]         count;
  logic [1:0]         status;

  // local copy of the list contents
  logic signed [31:0] list_cells[CAPACITY];
  int unsigned        list_fill;

  list_result_t       pending_results[$];
  int unsigned        mismatches;
  int unsigned        quiet_cycles;
  int unsigned        sender_idle_pct;
  int unsigned        receiver_stall_pct;

  ordered_array_list #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .position(position),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_value(read_value),
    .count(count),
    .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    if (mismatches < REPORT_LIMIT) $display("ERROR: %s", msg);
    mismatches++;
  endtask

  // Apply one command to the local list and return the result it should give
  function automatic list_result_t list_step(logic [2:0] cmd, logic [3:0] pos,
                                             logic signed [31:0] val);
    list_result_t r;
    int i;
    r.read_value = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (list_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            for (i = list_fill; i > 0; i--) list_cells[i] = list_cells[i-1];
            list_cells[0] = val;
          end else begin
            list_cells[list_fill] = val;
          end
          list_fill++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (list_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (cmd == CMD_POP_FRONT)
            for (i = 0; i + 1 < list_fill; i++) list_cells[i] = list_cells[i+1];
          list_fill--;
        end
      end
      // position check comes before the full check
      CMD_INSERT: begin
        if (pos >= list_fill) begin
          r.status = ST_BADPOS;
        end else if (list_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_fill; i > pos; i--) list_cells[i] = list_cells[i-1];
          list_cells[pos] = val;
          list_fill++;
        end
      end
      CMD_ERASE: begin
        if (pos >= list_fill) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = pos; i + 1 < list_fill; i++) list_cells[i] = list_cells[i+1];
          list_fill--;
        end
      end
      CMD_READ: begin
        if (pos >= list_fill) r.status = ST_BADPOS;
        else r.read_value = list_cells[pos];
      end
      default: begin
      end
    endcase
    r.count = 5'(list_fill);
    return r;
  endfunction

  // Words biased towards the extremes
  function automatic logic signed [31:0] random_word();
    case ($urandom_range(9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  // One command transfer, with random idle cycles before it
  task automatic send_command(logic [2:0] cmd, logic [3:0] pos, logic signed [31:0] val);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    position <= pos;
    value <= val;
    do @(posedge clk); while (in_stall);
    pending_results = {pending_results, list_step(cmd, pos, val)};
  endtask

  // Pops, position errors and the unused code on an empty list
  task automatic test_empty_list();
    send_command(CMD_POP_FRONT, 4'd0, WORD_MAX);
    send_command(CMD_POP_BACK, 4'd15, WORD_MIN);
    send_command(CMD_INSERT, 4'd0, WORD_MAX);
    send_command(CMD_ERASE, 4'd0, '0);
    send_command(CMD_READ, 4'd0, '1);
    send_command(CMD_UNUSED, 4'd15, WORD_MIN);
  endtask

  // Insert before the last entry shifts rather than appends
  task automatic test_shift_and_read();
    send_command(CMD_PUSH_BACK, 4'd0, WORD_MIN);
    send_command(CMD_PUSH_FRONT, 4'd0, WORD_MAX);
    send_command(CMD_INSERT, 4'd1, '1);
    send_command(CMD_READ, 4'd1, '0);
    send_command(CMD_READ, 4'd2, '0);
    send_command(CMD_ERASE, 4'd0, '0);
  endtask

  // Fill to capacity, then the full cases and non-empty pops
  task automatic test_fill_to_capacity();
    while (list_fill < CAPACITY)
      send_command(list_fill[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, 4'($urandom()),
                   random_word());
    send_command(CMD_PUSH_FRONT, 4'd0, WORD_MAX);
    send_command(CMD_INSERT, 4'd7, WORD_MIN);
    send_command(CMD_READ, 4'd15, '0);
    send_command(CMD_POP_FRONT, 4'd0, '0);
    send_command(CMD_POP_BACK, 4'd0, '0);
  endtask

  // Mostly well-formed traffic that swings the list between empty and full
  task automatic test_random_traffic(int unsigned sender_pct, int unsigned receiver_pct,
                                     int unsigned n_items);
    int unsigned sent;
    int unsigned roll;
    int unsigned pick;
    bit growing;
    logic [2:0] cmd;
    logic [3:0] pos;
    sender_idle_pct = sender_pct;
    receiver_stall_pct = receiver_pct;
    sent = 0;
    growing = (list_fill < CAPACITY / 2);
    while (sent < n_items) begin
      if (list_fill == CAPACITY) growing = 1'b0;
      else if (list_fill == 0) growing = 1'b1;
      roll = $urandom_range(99);
      pick = $urandom_range(2);
      if (roll < 3)
        cmd = CMD_UNUSED;
      else if (roll < 60 && growing)
        cmd = (pick == 0) ? CMD_PUSH_FRONT : (pick == 1) ? CMD_PUSH_BACK : CMD_INSERT;
      else if (roll < 60)
        cmd = (pick == 0) ? CMD_POP_FRONT : (pick == 1) ? CMD_POP_BACK : CMD_ERASE;
      else
        cmd = 3'($urandom_range(CMD_READ));
      if (list_fill != 0 && $urandom_range(9) != 0) pos = 4'($urandom_range(list_fill - 1));
      else pos = 4'($urandom_range(15));
      send_command(cmd, pos, random_word());
      if (cmd != CMD_UNUSED) sent++;
    end
  endtask

  // Receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: count=%0d status=%0d",
                                  count, status));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (read_value !== want.read_value)
          report_mismatch($sformatf("read_value %0d, want %0d", read_value,
                                    want.read_value));
        if (count !== want.count)
          report_mismatch($sformatf("count %0d, want %0d", count, want.count));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ordered_array_list: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_PUSH_FRONT;
    position = '0;
    value = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    mismatches = 0;
    list_fill = 0;
    foreach (list_cells[i]) list_cells[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_shift_and_read();
    test_fill_to_capacity();
    test_random_traffic(0, 0, 285);
    test_random_traffic(81, 0, 285);
    test_random_traffic(0, 81, 285);
    test_random_traffic(16, 16, 285);

    // drain outstanding results
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatches == 0) begin
      $display("ordered_array_list: match");
    end else begin
      $display("ordered_array_list: mismatch");
    end
    $finish;
  end

endmodule
